// ----- hw/rtl/ggcd_pkg.sv -----
package ggcd_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int DIFF_W       = DATA_W + 1;
  localparam int DIV_NUM_W    = DATA_W + FRAC_W;
  localparam int OUT_ROW_W    = 8;
  localparam int OUT_COL_W    = 12;
  localparam int NUM_ROWS_W   = 9;
  localparam int NUM_COLS_W   = 13;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 4096;
  localparam int MIN_DIM      = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int SLOT_W       = 2;

  // Queue entry without the row and column indexes: five words, slot, four flags.
  localparam int ENT_FIXED_W  = 5 * DATA_W + SLOT_W + 4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

endpackage

// ----- hw/rtl/ggcd_ram.sv -----
module ggcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ggcd_queue.sv -----
module ggcd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == NW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ggcd_div.sv -----
module ggcd_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ggcd_pkg::DIFF_W-1:0]   num,
  input  logic signed [ggcd_pkg::DIFF_W-1:0]   den,
  output logic                                 done,
  output logic [ggcd_pkg::DATA_W-1:0]          quo,
  output logic                                 zero_den
);

  localparam int DW  = ggcd_pkg::DATA_W;
  localparam int NW  = ggcd_pkg::DIV_NUM_W;
  localparam int CNW = $clog2(NW + 1);
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

  logic [NW-1:0]  n_r;
  logic [NW-1:0]  q_r;
  logic [DW-1:0]  d_r;
  logic [DW-1:0]  rem_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           neg_r;
  logic           done_r;
  logic           zero_r;
  logic [DW-1:0]  quo_r;

  logic [ggcd_pkg::DIFF_W-1:0] num_abs;
  logic [ggcd_pkg::DIFF_W-1:0] den_abs;
  logic [DW:0]                 rem_sh;
  logic                        fits;
  logic [DW-1:0]               rem_nxt;

  assign num_abs = num[ggcd_pkg::DIFF_W-1] ? -num : num;
  assign den_abs = den[ggcd_pkg::DIFF_W-1] ? -den : den;
  assign rem_sh  = {rem_r, n_r[NW-1]};
  assign fits    = (rem_sh >= {1'b0, d_r});
  assign rem_nxt = fits ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];

  // Restoring division of the magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= num[ggcd_pkg::DIFF_W-1] ^ den[ggcd_pkg::DIFF_W-1];
        zero_r <= (den == '0);
        if (den == '0) begin
          done_r <= 1'b1;
          if (num == '0) begin
            quo_r <= '0;
          end else if (num[ggcd_pkg::DIFF_W-1]) begin
            quo_r <= MAX_NEG;
          end else begin
            quo_r <= MAX_POS;
          end
        end else begin
          n_r    <= {num_abs[DW-1:0], {ggcd_pkg::FRAC_W{1'b0}}};
          d_r    <= den_abs[DW-1:0];
          rem_r  <= '0;
          q_r    <= '0;
          cnt_r  <= CNW'(NW);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[NW-2:0], fits};
          n_r   <= {n_r[NW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (!neg_r) begin
            quo_r <= (q_r[NW-1:DW-1] != '0) ? MAX_POS : q_r[DW-1:0];
          end else if ((q_r[NW-1:DW] != '0) || (q_r[DW-1] && (q_r[DW-2:0] != '0))) begin
            quo_r <= MAX_NEG;
          end else begin
            quo_r <= ~q_r[DW-1:0] + 1'b1;
          end
        end
      end
    end
  end

  assign done     = done_r;
  assign quo      = quo_r;
  assign zero_den = zero_r;

endmodule

// ----- hw/rtl/ggcd_front.sv -----
module ggcd_front #(
  parameter int MAX_ROWS = ggcd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ggcd_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ggcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ggcd_pkg::DATA_W-1:0]         in_sample_value,
  input  logic [ggcd_pkg::DATA_W-1:0]         in_row_coord,
  input  logic [ggcd_pkg::DATA_W-1:0]         in_col_coord,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [ggcd_pkg::ENT_FIXED_W + $clog2(MAX_ROWS) + $clog2(MAX_COLS) - 1:0] q_data,
  output logic [$clog2(MAX_ROWS):0]           nr
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  typedef struct packed {
    logic [ggcd_pkg::DATA_W-1:0] sample;
    logic [ggcd_pkg::DATA_W-1:0] rcoord;
    logic [ggcd_pkg::DATA_W-1:0] ycur;
    logic [ggcd_pkg::DATA_W-1:0] yp0;
    logic [ggcd_pkg::DATA_W-1:0] yp1;
    logic [RW-1:0]               row;
    logic [CW-1:0]               col;
    logic [ggcd_pkg::SLOT_W-1:0] slot;
    logic                        col0;
    logic                        col1;
    logic                        lastcol;
    logic                        final_pt;
  } entry_t;

  logic [ggcd_pkg::NUM_ROWS_W-1:0] num_rows_r;
  logic [ggcd_pkg::NUM_COLS_W-1:0] num_cols_r;
  logic [RW-1:0]                   row_r;
  logic [CW-1:0]                   col_r;
  logic [ggcd_pkg::SLOT_W-1:0]     slot_r;
  logic [ggcd_pkg::DATA_W-1:0]     yp0_r;
  logic [ggcd_pkg::DATA_W-1:0]     yp1_r;

  logic [CW:0] nc;
  logic        accept;
  logic        row_wrap;
  logic        lastcol;
  entry_t      ent;

  always_comb begin
    if (num_rows_r < ggcd_pkg::NUM_ROWS_W'(ggcd_pkg::MIN_DIM)) begin
      nr = (RW+1)'(ggcd_pkg::MIN_DIM);
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      nr = (RW+1)'(MAX_ROWS);
    end else begin
      nr = (RW+1)'(num_rows_r);
    end
    if (num_cols_r < ggcd_pkg::NUM_COLS_W'(ggcd_pkg::MIN_DIM)) begin
      nc = (CW+1)'(ggcd_pkg::MIN_DIM);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      nc = (CW+1)'(MAX_COLS);
    end else begin
      nc = (CW+1)'(num_cols_r);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept;
  assign row_wrap  = ({1'b0, row_r} + 1'b1) >= nr;
  assign lastcol   = ({1'b0, col_r} + 1'b1) == nc;

  always_comb begin
    ent.sample   = in_sample_value;
    ent.rcoord   = in_row_coord;
    ent.ycur     = in_col_coord;
    ent.yp0      = yp0_r;
    ent.yp1      = yp1_r;
    ent.row      = row_r;
    ent.col      = col_r;
    ent.slot     = slot_r;
    ent.col0     = (col_r == '0);
    ent.col1     = (col_r == CW'(1));
    ent.lastcol  = lastcol;
    ent.final_pt = row_wrap && lastcol;
  end

  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ggcd_pkg::NUM_ROWS_W'(ggcd_pkg::MIN_DIM);
      num_cols_r <= ggcd_pkg::NUM_COLS_W'(ggcd_pkg::MIN_DIM);
      row_r      <= '0;
      col_r      <= '0;
      slot_r     <= '0;
    end else if (cfg_valid) begin
      // Any write to a known register starts a new grid.
      if (cfg_index == ggcd_pkg::REG_NUM_ROWS) begin
        num_rows_r <= cfg_data[ggcd_pkg::NUM_ROWS_W-1:0];
        row_r      <= '0;
        col_r      <= '0;
        slot_r     <= '0;
      end else if (cfg_index == ggcd_pkg::REG_NUM_COLS) begin
        num_cols_r <= cfg_data;
        row_r      <= '0;
        col_r      <= '0;
        slot_r     <= '0;
      end
    end else if (accept) begin
      if (row_wrap) begin
        row_r <= '0;
        if (lastcol) begin
          col_r  <= '0;
          slot_r <= '0;
        end else begin
          col_r  <= col_r + 1'b1;
          slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 1'b1;
        end
      end else begin
        row_r <= row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_wrap) begin
      yp1_r <= yp0_r;
      yp0_r <= in_col_coord;
    end
  end

endmodule

// ----- hw/rtl/ggcd_back.sv -----
module ggcd_back #(
  parameter int MAX_ROWS = ggcd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ggcd_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic [ggcd_pkg::ENT_FIXED_W + $clog2(MAX_ROWS) + $clog2(MAX_COLS) - 1:0] q_data,
  input  logic [$clog2(MAX_ROWS):0]           nr,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ggcd_pkg::OUT_ROW_W-1:0]      out_row,
  output logic [ggcd_pkg::OUT_COL_W-1:0]      out_col,
  output logic [ggcd_pkg::DATA_W-1:0]         out_grad_row_dir,
  output logic [ggcd_pkg::DATA_W-1:0]         out_grad_col_dir,
  output logic                                out_zero_span,
  output logic                                out_last_of_run,
  output logic                                out_grid_done
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int DW = ggcd_pkg::DATA_W;

  typedef struct packed {
    logic [DW-1:0]               sample;
    logic [DW-1:0]               rcoord;
    logic [DW-1:0]               ycur;
    logic [DW-1:0]               yp0;
    logic [DW-1:0]               yp1;
    logic [RW-1:0]               row;
    logic [CW-1:0]               col;
    logic [ggcd_pkg::SLOT_W-1:0] slot;
    logic                        col0;
    logic                        col1;
    logic                        lastcol;
    logic                        final_pt;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
    ST_DX, ST_DXW, ST_DY, ST_DYW, ST_EMIT
  } state_t;

  // Which result of the current item is being worked on.
  typedef enum logic [1:0] {
    RES_PREV_COL, RES_LAST_PREV_ROW, RES_LAST_FINAL
  } res_t;

  state_t        state_r;
  res_t          kind_r;
  entry_t        ent_r;
  logic [RW-1:0] r_r;
  logic [DW-1:0] a_r, b_r, c_r, d_r, x_r, y_r;
  logic [DW-1:0] gx_r;
  logic          zx_r;
  logic [DW-1:0] gy_r;
  logic          zy_r;

  logic                        out_valid_r;
  logic [ggcd_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [ggcd_pkg::OUT_COL_W-1:0] out_col_r;
  logic [DW-1:0]               out_gx_r;
  logic [DW-1:0]               out_gy_r;
  logic                        out_zero_r;
  logic                        out_last_r;
  logic                        out_done_r;

  logic [DW-1:0]               col_rd [3];
  logic [2:0]                  col_we;
  logic [DW-1:0]               rc_rd;
  logic [RW-1:0]               rd_addr;
  logic [RW-1:0]               hi, lo;
  logic [ggcd_pkg::SLOT_W-1:0] slot_prev, slot_pp, gs, ts;
  logic [DW-1:0]               col_g, col_j, col_t;
  logic                        use_pp;

  logic                               div_start;
  logic signed [ggcd_pkg::DIFF_W-1:0] div_num, div_den;
  logic signed [ggcd_pkg::DIFF_W-1:0] gx_num, gx_den, gy_num, gy_den;
  logic                               div_done;
  logic [DW-1:0]                      div_quo;
  logic                               div_zero;
  logic                               out_free;
  logic                               last_flag;

  function automatic logic [DW-1:0] pick(input logic [ggcd_pkg::SLOT_W-1:0] s,
                                         input logic [DW-1:0] v0,
                                         input logic [DW-1:0] v1,
                                         input logic [DW-1:0] v2);
    logic [DW-1:0] v;
    unique case (s)
      2'd0:    v = v0;
      2'd1:    v = v1;
      default: v = v2;
    endcase
    return v;
  endfunction

  assign slot_prev = (ent_r.slot == 2'd0) ? 2'd2 : ent_r.slot - 1'b1;
  assign slot_pp   = (slot_prev == 2'd0) ? 2'd2 : slot_prev - 1'b1;
  assign use_pp    = (kind_r == RES_PREV_COL) && !ent_r.col1;
  assign gs        = (kind_r == RES_PREV_COL) ? slot_prev : ent_r.slot;
  assign ts        = use_pp ? slot_pp : slot_prev;
  assign col_g     = pick(gs, col_rd[0], col_rd[1], col_rd[2]);
  assign col_j     = pick(ent_r.slot, col_rd[0], col_rd[1], col_rd[2]);
  assign col_t     = pick(ts, col_rd[0], col_rd[1], col_rd[2]);

  // Neighbor rows for the derivative along rows; edges fall back to one side.
  always_comb begin
    if (r_r == '0) begin
      lo = '0;
      hi = RW'(1);
    end else if (({1'b0, r_r} + 1'b1) >= nr) begin
      lo = RW'(nr - 2'd2);
      hi = RW'(nr - 1'b1);
    end else begin
      lo = r_r - 1'b1;
      hi = r_r + 1'b1;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_RD0:  rd_addr = hi;
      ST_RD1:  rd_addr = lo;
      default: rd_addr = r_r;
    endcase
  end

  always_comb begin
    col_we = '0;
    if (state_r == ST_WRITE) begin
      col_we[ent_r.slot] = 1'b1;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_col
    ggcd_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_col (
      .clk   (clk),
      .we    (col_we[k]),
      .waddr (ent_r.row),
      .wdata (ent_r.sample),
      .raddr (rd_addr),
      .rdata (col_rd[k])
    );
  end

  ggcd_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_rcoord (
    .clk   (clk),
    .we    ((state_r == ST_WRITE) && ent_r.col0),
    .waddr (ent_r.row),
    .wdata (ent_r.rcoord),
    .raddr (rd_addr),
    .rdata (rc_rd)
  );

  assign gx_num = {a_r[DW-1], a_r} - {b_r[DW-1], b_r};
  assign gx_den = {c_r[DW-1], c_r} - {d_r[DW-1], d_r};
  assign gy_num = {x_r[DW-1], x_r} - {y_r[DW-1], y_r};
  assign gy_den = use_pp ? ({ent_r.ycur[DW-1], ent_r.ycur} - {ent_r.yp1[DW-1], ent_r.yp1})
                         : ({ent_r.ycur[DW-1], ent_r.ycur} - {ent_r.yp0[DW-1], ent_r.yp0});

  assign div_start = (state_r == ST_DX) || (state_r == ST_DY);
  assign div_num   = (state_r == ST_DX) ? gx_num : gy_num;
  assign div_den   = (state_r == ST_DX) ? gx_den : gy_den;

  ggcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .zero_den (div_zero)
  );

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (kind_r)
      RES_PREV_COL:      last_flag = !(ent_r.lastcol && (ent_r.row != '0));
      RES_LAST_PREV_ROW: last_flag = !ent_r.final_pt;
      default:           last_flag = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= RES_PREV_COL;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            ent_r   <= q_data;
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (ent_r.col0) begin
            state_r <= ST_IDLE;
          end else begin
            kind_r  <= RES_PREV_COL;
            r_r     <= ent_r.row;
            state_r <= ST_RD0;
          end
        end
        ST_RD0: state_r <= ST_RD1;
        ST_RD1: begin
          a_r     <= col_g;
          c_r     <= rc_rd;
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          b_r     <= col_g;
          d_r     <= rc_rd;
          state_r <= ST_RD3;
        end
        ST_RD3: begin
          x_r     <= col_j;
          y_r     <= col_t;
          state_r <= ST_DX;
        end
        ST_DX: state_r <= ST_DXW;
        ST_DXW: begin
          if (div_done) begin
            gx_r    <= div_quo;
            zx_r    <= div_zero;
            state_r <= ST_DY;
          end
        end
        ST_DY: state_r <= ST_DYW;
        ST_DYW: begin
          if (div_done) begin
            gy_r    <= div_quo;
            zy_r    <= zx_r | div_zero;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= ggcd_pkg::OUT_ROW_W'(r_r);
            out_col_r   <= (kind_r == RES_PREV_COL) ? ggcd_pkg::OUT_COL_W'(ent_r.col - 1'b1)
                                                    : ggcd_pkg::OUT_COL_W'(ent_r.col);
            out_gx_r    <= gx_r;
            out_gy_r    <= gy_r;
            out_zero_r  <= zy_r;
            out_last_r  <= last_flag;
            out_done_r  <= (kind_r == RES_LAST_FINAL);
            unique case (kind_r)
              RES_PREV_COL: begin
                if (ent_r.lastcol && (ent_r.row != '0)) begin
                  kind_r  <= RES_LAST_PREV_ROW;
                  r_r     <= ent_r.row - 1'b1;
                  state_r <= ST_RD0;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              RES_LAST_PREV_ROW: begin
                if (ent_r.final_pt) begin
                  kind_r  <= RES_LAST_FINAL;
                  r_r     <= ent_r.row;
                  state_r <= ST_RD0;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_grad_row_dir = out_gx_r;
  assign out_grad_col_dir = out_gy_r;
  assign out_zero_span    = out_zero_r;
  assign out_last_of_run  = out_last_r;
  assign out_grid_done    = out_done_r;

endmodule

// ----- hw/rtl/grid_gradient_central_difference_core.sv -----
// Channel  Direction  Handshake              Transaction
// in_      input      in_valid / in_stall    one grid sample with row and column coordinates
// out_     output     out_valid / out_stall  one gradient result for one grid point
// cfg_     input      cfg_valid / cfg_ready  one register write (index, data)
//
// Items of column 0 are only written to the stores. Every other item gives
// one to three results, and each result takes four memory reads and two
// passes through the shared bit-serial divider.
// Synchronous active-low reset clears the counters, queue and sequencer; stores
// keep their contents. A two-entry queue keeps accepting while the back end
// waits on a stalled output register.
module grid_gradient_central_difference_core #(
  parameter int MAX_ROWS = ggcd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ggcd_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ggcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ggcd_pkg::DATA_W-1:0]     in_sample_value,
  input  logic [ggcd_pkg::DATA_W-1:0]     in_row_coord,
  input  logic [ggcd_pkg::DATA_W-1:0]     in_col_coord,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ggcd_pkg::OUT_ROW_W-1:0]  out_row,
  output logic [ggcd_pkg::OUT_COL_W-1:0]  out_col,
  output logic [ggcd_pkg::DATA_W-1:0]     out_grad_row_dir,
  output logic [ggcd_pkg::DATA_W-1:0]     out_grad_col_dir,
  output logic                            out_zero_span,
  output logic                            out_last_of_run,
  output logic                            out_grid_done
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int ENT_W = ggcd_pkg::ENT_FIXED_W + RW + CW;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [ENT_W-1:0] q_wdata;
  logic [ENT_W-1:0] q_rdata;
  logic [RW:0]      nr;

  ggcd_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_row_coord    (in_row_coord),
    .in_col_coord    (in_col_coord),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .nr              (nr)
  );

  ggcd_queue #(.WIDTH(ENT_W), .DEPTH(ggcd_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  ggcd_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .nr               (nr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_grad_row_dir (out_grad_row_dir),
    .out_grad_col_dir (out_grad_col_dir),
    .out_zero_span    (out_zero_span),
    .out_last_of_run  (out_last_of_run),
    .out_grid_done    (out_grid_done)
  );

endmodule

// ----- dv/tb_grid_gradient_central_difference_core.sv -----
`timescale 1ns / 100ps

module tb_grid_gradient_central_difference_core;
  import ggcd_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] rcoord;
    logic [DATA_W-1:0] ccoord;
  } grid_sample_t;

  typedef struct {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [DATA_W-1:0]    grad_row;
    logic [DATA_W-1:0]    grad_col;
    logic                 zero_span;
    logic                 last_of_run;
    logic                 grid_done;
  } gradient_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_sample_value = '0;
  logic [DATA_W-1:0]     in_row_coord = '0;
  logic [DATA_W-1:0]     in_col_coord = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic [DATA_W-1:0]     out_grad_row_dir;
  logic [DATA_W-1:0]     out_grad_col_dir;
  logic                  out_zero_span;
  logic                  out_last_of_run;
  logic                  out_grid_done;

  grid_gradient_central_difference_core dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow state of the gradient engine.
  logic [DATA_W-1:0]     col_samples [3][DEF_MAX_ROWS];
  logic [DATA_W-1:0]     row_coords [DEF_MAX_ROWS];
  logic [DATA_W-1:0]     prev_ycoord [2];
  int unsigned           row_pos = 0;
  int unsigned           col_pos = 0;
  logic [NUM_ROWS_W-1:0] rows_reg = NUM_ROWS_W'(MIN_DIM);
  logic [NUM_COLS_W-1:0] cols_reg = NUM_COLS_W'(MIN_DIM);

  grid_sample_t pending_q[$];
  gradient_t    gradient_q[$];
  int           errors = 0;
  int           accepted = 0;
  logic         hold_on = 1'b0;

  function automatic longint sx(logic [DATA_W-1:0] v);
    return longint'($signed(v));
  endfunction

  // Bit 32 flags a zero span.
  function automatic logic [DATA_W:0] slope(longint num, longint den);
    longint q;
    if (den == 0) begin
      if (num > 0) return {1'b1, 32'h7FFF_FFFF};
      if (num < 0) return {1'b1, 32'h8000_0000};
      return {1'b1, 32'h0};
    end
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return {1'b0, q[31:0]};
  endfunction

  function automatic logic [DATA_W:0] row_slope(int slot, int unsigned r, int unsigned nr);
    int unsigned lo, hi;
    if (r == 0) begin
      lo = 0; hi = 1;
    end else if (r + 1 >= nr) begin
      lo = nr - 2; hi = nr - 1;
    end else begin
      lo = r - 1; hi = r + 1;
    end
    return slope(sx(col_samples[slot][hi]) - sx(col_samples[slot][lo]),
                 sx(row_coords[hi]) - sx(row_coords[lo]));
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_reg < MIN_DIM) return MIN_DIM;
    if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg < MIN_DIM) return MIN_DIM;
    if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return cols_reg;
  endfunction

  task automatic predict_gradients(grid_sample_t it);
    int unsigned nr, nc, i, j, c, r, r0, lst;
    longint ycur, yp0, yp1, num;
    logic final_item;
    logic [DATA_W:0] gx, gy;
    int n;
    gradient_t g;
    nr = eff_rows();
    nc = eff_cols();
    i = row_pos;
    j = col_pos;
    lst = nc - 1;
    ycur = sx(it.ccoord);
    yp0 = sx(prev_ycoord[0]);
    yp1 = sx(prev_ycoord[1]);
    final_item = (i + 1 == nr) && (j == lst);
    n = 0;
    if (i >= nr) i = nr - 1;
    col_samples[j % 3][i] = it.sample;
    if (j == 0) row_coords[i] = it.rcoord;
    if (j >= 1) begin
      c = j - 1;
      gx = row_slope(c % 3, i, nr);
      num = sx(col_samples[j % 3][i]);
      if (c == 0) begin
        num -= sx(col_samples[0][i]);
        gy = slope(num, ycur - yp0);
      end else begin
        num -= sx(col_samples[(c - 1) % 3][i]);
        gy = slope(num, ycur - yp1);
      end
      g = '{OUT_ROW_W'(i), OUT_COL_W'(c), gx[31:0], gy[31:0], gx[32] | gy[32], 1'b0, 1'b0};
      gradient_q.push_back(g);
      n++;
    end
    if (j == lst) begin
      r0 = (i >= 1) ? i - 1 : i;
      for (r = r0; r <= i; r++) begin
        if (r == i && !final_item) break;
        if (r == i && i >= 1 && r0 == i) break;
        gx = row_slope(j % 3, r, nr);
        gy = slope(sx(col_samples[j % 3][r]) - sx(col_samples[(j - 1) % 3][r]), ycur - yp0);
        g = '{OUT_ROW_W'(r), OUT_COL_W'(j), gx[31:0], gy[31:0], gx[32] | gy[32], 1'b0,
              (r + 1 == nr)};
        gradient_q.push_back(g);
        n++;
      end
    end
    if (n > 0) gradient_q[gradient_q.size() - 1].last_of_run = 1'b1;
    if (i + 1 >= nr) begin
      prev_ycoord[1] = prev_ycoord[0];
      prev_ycoord[0] = it.ccoord;
      row_pos = 0;
      col_pos = (j + 1 >= nc) ? 0 : j + 1;
    end else begin
      row_pos = i + 1;
    end
  endtask

  // Driver: one transaction per accepted sample, random gaps between them.
  int in_gap = 0;
  logic in_quiet = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      predict_gradients(pending_q.pop_front());
      accepted++;
      if ($urandom_range(0, 39) == 0) in_quiet = ~in_quiet;
      in_gap = in_quiet ? 0 : $urandom_range(0, 18);
      if (in_gap == 0 && pending_q.size() > 0) begin
        in_sample_value <= pending_q[0].sample;
        in_row_coord    <= pending_q[0].rcoord;
        in_col_coord    <= pending_q[0].ccoord;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() > 0) begin
        in_valid        <= 1'b1;
        in_sample_value <= pending_q[0].sample;
        in_row_coord    <= pending_q[0].rcoord;
        in_col_coord    <= pending_q[0].ccoord;
      end
    end
  end

  // Monitor and receiver stall.
  int out_gap = 0;
  logic out_quiet = 1'b0;
  always @(posedge clk) begin
    gradient_t e;
    if (out_valid && !out_stall) begin
      if (gradient_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result row %0d col %0d", out_row, out_col);
      end else begin
        e = gradient_q.pop_front();
        if (out_row !== e.row || out_col !== e.col || out_grad_row_dir !== e.grad_row ||
            out_grad_col_dir !== e.grad_col || out_zero_span !== e.zero_span ||
            out_last_of_run !== e.last_of_run || out_grid_done !== e.grid_done) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch exp r%0d c%0d gx %h gy %h z%b l%b d%b",
                      " / got r%0d c%0d gx %h gy %h z%b l%b d%b"},
                     e.row, e.col, e.grad_row, e.grad_col, e.zero_span, e.last_of_run,
                     e.grid_done, out_row, out_col, out_grad_row_dir, out_grad_col_dir,
                     out_zero_span, out_last_of_run, out_grid_done);
        end
      end
      if ($urandom_range(0, 29) == 0) out_quiet = ~out_quiet;
      out_gap = out_quiet ? 0 : $urandom_range(0, 18);
    end else if (out_gap > 0 && out_stall) begin
      out_gap--;
    end
    out_stall <= hold_on || (out_gap > 0);
  end

  // Long receiver hold-off while the sender keeps offering samples.
  initial begin
    wait (accepted >= 120);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_ROWS) begin
      rows_reg = val[NUM_ROWS_W-1:0];
      row_pos = 0; col_pos = 0;
    end else if (idx == REG_NUM_COLS) begin
      cols_reg = val[NUM_COLS_W-1:0];
      row_pos = 0; col_pos = 0;
    end
  endtask

  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid && gradient_q.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample(int style);
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return DATA_W'($signed($urandom_range(0, 8191)) - 4096);
      default: return (style == 1) ? 32'h0 : $urandom;
    endcase
  endfunction

  // Queues a grid in column-major order; flat spans show up now and then.
  task automatic queue_grid(int unsigned nr, int unsigned count, int noisy);
    logic [DATA_W-1:0] rc, yc;
    grid_sample_t it;
    rc = $urandom;
    yc = $urandom;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % nr == 0 && k > 0) begin
        yc = yc + (($urandom_range(0, 9) == 0) ? 32'h0 : $urandom_range(1, 32'h4_0000));
      end
      if (k % nr == 0) rc = $urandom;
      else rc = rc + (($urandom_range(0, 9) == 0) ? 32'h0 : $urandom_range(1, 32'h3_0000));
      it.sample = pick_sample(0);
      it.rcoord = rc;
      it.ccoord = yc;
      if (noisy) begin
        it.rcoord = $urandom;
        it.ccoord = $urandom;
      end
      pending_q.push_back(it);
    end
  endtask

  initial begin
    int unsigned nr, nc, cnt, rnd_items;
    grid_sample_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes, extreme samples and coordinates.
    for (int k = 0; k < 9; k++) begin
      it.sample = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      it.rcoord = (k % 3 == 0) ? 32'h8000_0000 : ((k % 3 == 1) ? 32'h0 : 32'h7FFF_FFFF);
      it.ccoord = (k / 3 == 0) ? 32'h8000_0000 : ((k / 3 == 1) ? 32'h0 : 32'h7FFF_FFFF);
      pending_q.push_back(it);
    end
    settle();
    // Flat grid: every span is zero.
    write_reg(REG_NUM_ROWS, 13'd3);
    write_reg(REG_NUM_COLS, 13'd3);
    for (int k = 0; k < 9; k++) begin
      it.sample = (k % 3 == 1) ? 32'h0 : pick_sample(0);
      it.rcoord = 32'h0001_0000;
      it.ccoord = 32'h0002_0000;
      pending_q.push_back(it);
    end
    settle();
    // Register values below and above the legal range, plus an unused index.
    write_reg(REG_NUM_ROWS, 13'h1FFF);
    write_reg(REG_NUM_COLS, 13'h0);
    write_reg(CFG_IDX_W'(2), 13'h1555);
    queue_grid(256, 4, 0);
    settle();
    write_reg(REG_NUM_ROWS, 13'h0);
    write_reg(REG_NUM_COLS, 13'h1FFF);
    queue_grid(3, 12, 0);
    settle();

    rnd_items = 0;
    while (rnd_items < 320) begin
      nr = $urandom_range(3, 7);
      nc = $urandom_range(3, 5);
      if ($urandom_range(0, 11) == 0) nr = 256;
      write_reg(REG_NUM_ROWS, CFG_DATA_W'(nr) | ($urandom_range(0, 3) == 0 ?
                CFG_DATA_W'($urandom) & 13'h1E00 : 13'h0));
      write_reg(REG_NUM_COLS, CFG_DATA_W'(nc));
      cnt = nr * nc;
      if (nr == 256) cnt = $urandom_range(2, 40);
      else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, cnt - 1);
      queue_grid(nr, cnt, $urandom_range(0, 9) == 0);
      rnd_items += cnt;
      settle();
    end

    if (errors == 0 && gradient_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
